@@ sv/disc_window_color_contrast_assert.svh @@
// Assertion macros shared by the checker of the disc window contrast block.
// No dependencies.
`ifndef DISC_WINDOW_COLOR_CONTRAST_ASSERT_SVH
`define DISC_WINDOW_COLOR_CONTRAST_ASSERT_SVH
// implication checked every cycle outside reset
`define DWC_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("check failed");
// implication checked in the next cycle
`define DWC_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("check failed");
// hold valid and payload while the consumer stalls
`define DWC_ASSERT_HOLD(label, clk, rst, vld, rdy, sig) \
   label: assert property (@(posedge clk) disable iff (rst) \
      (vld) && !(rdy) |=> (vld) && $stable(sig)) \
      else $error("check failed");
`endif

@@ sv/dwcc_pkg.sv @@
// Shared types and constants for the disc window contrast block.
// No dependencies.
package dwcc_pkg;
   localparam int unsigned ROW_SLOTS_W = 6;
   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;
   localparam logic [7:0] CHAN_MAX   = 8'hff;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DRAIN, ST_SQRT, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;     // accept pixel, write store, load the disc scan registers
      logic scan_step; // issue next disc read
      logic sqrt_start;
      logic sqrt_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic emit;      // accepted pixel completes a disc
      logic scan_done; // last window position stepped
      logic sqrt_done;
   } sts_type;
endpackage

@@ sv/dwcc_ctrl.sv @@
// Controller state machine of the disc window contrast block.
// Depends on dwcc_pkg.
module dwcc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic              out_free,
   input  dwcc_pkg::sts_type sts,
   output dwcc_pkg::cmd_type cmd,
   output logic              busy
);
   import dwcc_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_fire && sts.emit) state_in = ST_SCAN;
         ST_SCAN:  if (sts.scan_done) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_SQRT;
         ST_SQRT:  if (sts.sqrt_done) state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE:  begin busy = 1'b0; cmd.start = req_fire; end
         ST_SCAN:  cmd.scan_step = 1'b1;
         ST_DRAIN: cmd.sqrt_start = 1'b1;
         ST_SQRT:  cmd.sqrt_step = 1'b1;
         ST_OUT:   cmd.out_load = out_free;
         default:  busy = 1'b1;
      endcase
   end
endmodule

@@ sv/dwcc_datapath.sv @@
// Datapath: line store, position counters, disc scan, min/max, square root.
// Depends on dwcc_pkg.
module dwcc_datapath #(
   parameter int unsigned MAX_RADIUS = 16,
   parameter int unsigned MAX_WIDTH  = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  dwcc_pkg::cmd_type cmd,
   output dwcc_pkg::sts_type sts,
   input  logic [23:0]       pix,
   input  logic              frame_start,
   input  logic [4:0]        radius,
   input  logic [11:0]       image_width,
   input  logic [11:0]       image_height,
   output logic [10:0]       centre_x,
   output logic [10:0]       centre_y,
   output logic [12:0]       contrast,
   output logic              frame_end
);
   import dwcc_pkg::*;
   localparam int unsigned SLOTS = 2 * MAX_RADIUS + 1;
   localparam int unsigned SW = $clog2(SLOTS);
   localparam int unsigned XW = $clog2(MAX_WIDTH);
   localparam int unsigned DW = $clog2(2 * MAX_RADIUS + 1);
   localparam int unsigned RW = $clog2(MAX_RADIUS + 1);

   logic [23:0] mem [0:SLOTS*MAX_WIDTH-1];
   logic [23:0] rd_ff;

   logic [12:0] col_ff, col_in, row_ff, row_in;
   logic [12:0] w_eff, h_eff;
   logic [RW-1:0] r_eff;
   logic [12:0] cc, rc;
   logic        store_ok;

   always_comb begin
      if (radius == 5'd0) r_eff = RW'(1);
      else if (32'(radius) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
      else r_eff = RW'(radius);
      w_eff = (32'(image_width) > MAX_WIDTH) ? 13'(MAX_WIDTH) : {1'b0, image_width};
      h_eff = (image_height > 12'd2048) ? 13'd2048 : {1'b0, image_height};
      cc = frame_start ? 13'd0 : col_ff;
      rc = frame_start ? 13'd0 : row_ff;
      store_ok = (w_eff != 13'd0) && (rc < h_eff) && (cc < w_eff);
   end

   // slot of the current row, tracked by counter instead of a modulo
   logic [SW-1:0] slot_ff, slot_in, sc;
   assign sc = frame_start ? '0 : slot_ff;

   always_comb begin
      col_in = col_ff; row_in = row_ff; slot_in = slot_ff;
      if (cmd.start) begin
         if (store_ok) begin
            col_in = cc + 13'd1; row_in = rc; slot_in = sc;
            if (cc + 13'd1 >= w_eff) begin
               col_in = 13'd0; row_in = rc + 13'd1;
               slot_in = (32'(sc) == SLOTS - 1) ? '0 : sc + SW'(1);
            end
         end else begin
            col_in = cc; slot_in = sc;
            row_in = (rc > h_eff) ? h_eff : rc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0; slot_ff <= '0;
      end else begin
         col_ff <= col_in; row_ff <= row_in; slot_ff <= slot_in;
      end
   end

   logic [13:0] two_r;
   assign two_r = 14'(r_eff) << 1;
   assign sts.emit = store_ok && ({1'b0, cc} >= two_r) && ({1'b0, rc} >= two_r);

   // scan state
   logic [DW-1:0]   dx_ff, dy_ff;
   logic [SW-1:0]   sy_ff;          // slot of the row being read
   logic [XW-1:0]   x0_ff;          // leftmost column of the disc
   logic [RW-1:0]   rr_ff;
   logic [10:0]     cx_ff, cy_ff;
   logic            fe_ff, rdv_ff;
   logic [7:0]      lo_ff [3];
   logic [7:0]      hi_ff [3];
   logic [DW-1:0]   two_rd;
   logic [DW-1:0]   adx, ady;
   logic [2*RW:0]   dsq;
   logic            in_disc;
   logic            last;

   assign two_rd = DW'(two_r);
   assign adx = (dx_ff > DW'(rr_ff)) ? dx_ff - DW'(rr_ff) : DW'(rr_ff) - dx_ff;
   assign ady = (dy_ff > DW'(rr_ff)) ? dy_ff - DW'(rr_ff) : DW'(rr_ff) - dy_ff;
   assign dsq = (2*RW+1)'(adx) * (2*RW+1)'(adx) + (2*RW+1)'(ady) * (2*RW+1)'(ady);
   assign in_disc = dsq <= (2*RW+1)'(rr_ff) * (2*RW+1)'(rr_ff);
   assign last = (dx_ff == DW'(rr_ff) << 1) && (dy_ff == DW'(rr_ff) << 1);
   assign sts.scan_done = cmd.scan_step && last;

   logic [SW:0] slot_top;
   always_comb begin
      // slot of row cy-r = y-2r
      slot_top = {1'b0, sc} + SW'(SLOTS) - {1'b0, two_rd[SW-1:0]};
      if (slot_top >= (SW+1)'(SLOTS)) slot_top = slot_top - (SW+1)'(SLOTS);
   end

   always_ff @(posedge clock) begin
      rdv_ff <= cmd.scan_step && in_disc;
      if (cmd.start && store_ok)
         mem[32'(sc) * MAX_WIDTH + 32'(cc[XW-1:0])] <= pix;
      if (cmd.start) begin
         dx_ff <= '0; dy_ff <= '0;
         sy_ff <= slot_top[SW-1:0];
         x0_ff <= XW'(cc - 13'(two_r));
         rr_ff <= r_eff;
         cx_ff <= 11'(cc - 13'(r_eff));
         cy_ff <= 11'(rc - 13'(r_eff));
         fe_ff <= (cc == w_eff - 13'd1) && (rc == h_eff - 13'd1);
         for (int c = 0; c < 3; c++) begin
            lo_ff[c] <= CHAN_MAX; hi_ff[c] <= 8'd0;
         end
      end
      if (cmd.scan_step) begin
         if (in_disc)
            rd_ff <= mem[32'(sy_ff) * MAX_WIDTH + 32'(XW'(x0_ff + XW'(dx_ff)))];
         if (dx_ff == DW'(rr_ff) << 1) begin
            dx_ff <= '0; dy_ff <= dy_ff + DW'(1);
            sy_ff <= (32'(sy_ff) == SLOTS - 1) ? '0 : sy_ff + SW'(1);
         end else dx_ff <= dx_ff + DW'(1);
      end
      if (rdv_ff) begin
         for (int c = 0; c < 3; c++) begin
            if (rd_ff[23-8*c -: 8] < lo_ff[c]) lo_ff[c] <= rd_ff[23-8*c -: 8];
            if (rd_ff[23-8*c -: 8] > hi_ff[c]) hi_ff[c] <= rd_ff[23-8*c -: 8];
         end
      end
   end

   // sum of squared ranges at root start, then a bit-pair-per-cycle root
   logic [7:0]  d0, d1, d2;
   logic [17:0] sq_sum;
   logic [26:0] v_ff, res_ff, bit_ff;
   logic [26:0] trial;
   assign d0 = hi_ff[0] - lo_ff[0];
   assign d1 = hi_ff[1] - lo_ff[1];
   assign d2 = hi_ff[2] - lo_ff[2];
   assign sq_sum = 18'(d0) * 18'(d0) + 18'(d1) * 18'(d1) + 18'(d2) * 18'(d2);
   assign trial = res_ff + bit_ff;
   assign sts.sqrt_done = cmd.sqrt_step && (bit_ff == 27'd1);

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         v_ff <= {1'b0, sq_sum, 8'd0};
         res_ff <= '0;
         bit_ff <= 27'd1 << 26;
      end else if (cmd.sqrt_step) begin
         if (v_ff >= trial) begin
            v_ff <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else res_ff <= res_ff >> 1;
         bit_ff <= bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         centre_x <= cx_ff; centre_y <= cy_ff;
         contrast <= 13'(res_ff); frame_end <= fe_ff;
      end
   end
endmodule

@@ sv/disc_window_color_contrast.sv @@
// Disc window colour contrast: per-pixel morphological gradient over a
// circular window of an RGB888 raster, controller plus datapath.
// Depends on dwcc_pkg, dwcc_ctrl, dwcc_datapath.
// Pixels are accepted one per cycle while no disc is being evaluated or
// waiting for the output register. A pixel that completes an interior disc
// of radius r starts a scan that steps through the (2r+1)^2 window positions
// one per cycle, reading those in the disc through the single line-store read
// port, then a square root; border pixels start no scan. The result sits in
// an output register while the next pixel is taken. The line store holds
// 2*MAX_RADIUS+1 rows of MAX_WIDTH pixels and needs no clearing after reset.
module disc_window_color_contrast #(
   parameter int unsigned MAX_RADIUS = 16,
   parameter int unsigned MAX_WIDTH  = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red, green, blue
   input  logic        req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // centre_x, centre_y, contrast (zero filled)
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import dwcc_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic busy, req_fire, out_free, vld_ff;
   logic [4:0] radius_ff;
   logic [11:0] width_ff, height_ff;
   logic [10:0] cx, cy;
   logic [12:0] ct;
   logic [23:0] pix;

   assign req_tready = !busy;
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !vld_ff || rsp_tready;
   assign pix = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 5'd1; width_ff <= 12'd2048; height_ff <= 12'd2048;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_wdata[4:0];
            CSR_WIDTH:  width_ff <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (cmd.out_load) vld_ff <= 1'b1;
      else if (rsp_tready) vld_ff <= 1'b0;
   end

   dwcc_ctrl u_ctrl (
      .clock, .reset, .req_fire, .out_free, .sts, .cmd, .busy
   );

   dwcc_datapath #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock, .reset, .cmd, .sts, .pix, .frame_start(req_tuser),
      .radius(radius_ff), .image_width(width_ff), .image_height(height_ff),
      .centre_x(cx), .centre_y(cy), .contrast(ct), .frame_end(rsp_tlast)
   );

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = {5'd0, ct, cy, cx};
endmodule

@@ sv/dwcc_checker.sv @@
// Port-level checker for the disc window contrast block, bound to the top.
// Depends on disc_window_color_contrast_assert.svh.
`include "disc_window_color_contrast_assert.svh"
module dwcc_assertions (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   `DWC_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_tvalid, rsp_tready, {rsp_tdata, rsp_tlast})
   `DWC_ASSERT_IMP(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[39:35] == 5'd0)
   `DWC_ASSERT_IMP(a_contrast_range, clock, reset, rsp_tvalid, rsp_tdata[34:22] <= 13'd7067)
   `DWC_ASSERT_NEXT(a_idle_after_reset, clock, reset, $fell(reset), !rsp_tvalid)
   `DWC_ASSERT_IMP(a_ready_known, clock, reset, 1'b1, !$isunknown(req_tready))
endmodule

bind disc_window_color_contrast dwcc_assertions u_dwcc_assertions (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tlast
);
